/* src/lpad_pkg.sv */
// Shared types and constants for the long-press alarm dismiss block.
// Used by lpad_step and by the top level long_press_alarm_dismiss.
`timescale 1ns / 1ps
`default_nettype none

package lpad_pkg;

    // Field widths.
    localparam int HOLD_SECONDS_W = 6;
    localparam int RING_MS_W      = 24;
    localparam int BEEP_MS_W      = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 24;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_SECONDS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_RING_MS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BEEP_LENGTH_MS = 2'd2;

    // Register values after reset.
    localparam logic [HOLD_SECONDS_W-1:0] HOLD_SECONDS_RESET   = 6'd10;
    localparam logic [RING_MS_W-1:0]      MAX_RING_MS_RESET    = 24'd600000;
    localparam logic [BEEP_MS_W-1:0]      BEEP_LENGTH_MS_RESET = 16'd500;

    // The hold timer counts in whole seconds plus milliseconds within the
    // second, so no division is needed. Its 16-bit millisecond total
    // saturates at 65535, that is 65 seconds and 535 milliseconds.
    localparam int MS_PER_SECOND = 1000;
    localparam int HOLD_MS_LIMIT = 65535;
    localparam int HOLD_SUB_W    = 10;
    localparam int HOLD_SEC_W    = 7;
    localparam logic [HOLD_SEC_W-1:0] HOLD_SEC_SAT =
        HOLD_SEC_W'(HOLD_MS_LIMIT / MS_PER_SECOND);
    localparam logic [HOLD_SUB_W-1:0] HOLD_SUB_SAT =
        HOLD_SUB_W'(HOLD_MS_LIMIT % MS_PER_SECOND);
    localparam logic [HOLD_SUB_W-1:0] HOLD_SUB_LAST =
        HOLD_SUB_W'(MS_PER_SECOND - 1);

    // Ringing state carried from one word to the next.
    typedef struct packed {
        logic                      active;
        logic                      muted;
        logic [RING_MS_W-1:0]      ring_ms;
        logic [HOLD_SEC_W-1:0]     hold_sec;
        logic [HOLD_SUB_W-1:0]     hold_sub;
        logic [HOLD_SECONDS_W-1:0] seconds_left;
        logic [BEEP_MS_W-1:0]      beep_ms;
        logic                      beep_on;
        logic                      square;
    } state_t;

    // One result word.
    typedef struct packed {
        logic                      buzzer_level;
        logic                      led_level;
        logic                      ringing;
        logic [HOLD_SECONDS_W-1:0] countdown_seconds;
        logic                      dismissed;
        logic                      timed_out;
    } result_t;

endpackage

`default_nettype wire

/* src/lpad_step.sv */
// Next-state and result logic for one tick word of the alarm controller.
// Purely combinational; depends on lpad_pkg for the state and result types.
`timescale 1ns / 1ps
`default_nettype none

module lpad_step (
    input  var lpad_pkg::state_t                          state,
    input  wire                                           start_alarm,
    input  wire                                           button_held,
    input  wire                                           ms_tick,
    input  wire                                           tone_tick,
    input  wire [lpad_pkg::HOLD_SECONDS_W-1:0]            hold_seconds,
    input  wire [lpad_pkg::RING_MS_W-1:0]                 max_ring_ms,
    input  wire [lpad_pkg::BEEP_MS_W-1:0]                 beep_length_ms,
    output lpad_pkg::state_t                              state_next,
    output lpad_pkg::result_t                             result
);
    import lpad_pkg::*;

    logic                      dis;
    logic                      tmo;
    logic [HOLD_SEC_W-1:0]     hold_seconds_ext;
    logic [HOLD_SECONDS_W-1:0] target;
    logic                      hold_sat;
    state_t                    n;

    assign hold_seconds_ext = HOLD_SEC_W'(hold_seconds);

    always_comb
    begin
        n        = state;
        dis      = 1'b0;
        tmo      = 1'b0;
        target   = '0;
        hold_sat = 1'b0;

        if (start_alarm)
        begin
            // Fresh start: arm and restart every timer.
            n.active       = 1'b1;
            n.muted        = 1'b0;
            n.ring_ms      = '0;
            n.hold_sec     = '0;
            n.hold_sub     = '0;
            n.seconds_left = hold_seconds;
            n.beep_ms      = '0;
            n.beep_on      = 1'b0;
            n.square       = 1'b0;
        end
        else if (state.active)
        begin
            // Millisecond tick advances the ring and beep timers, saturating.
            if (ms_tick)
            begin
                if (n.ring_ms != '1)
                begin
                    n.ring_ms = n.ring_ms + 1'b1;
                end
                if (n.beep_ms != '1)
                begin
                    n.beep_ms = n.beep_ms + 1'b1;
                end
            end

            if (button_held)
            begin
                // First held word mutes and restarts the hold timer.
                hold_sat = (n.hold_sec == HOLD_SEC_SAT) && (n.hold_sub == HOLD_SUB_SAT);
                if (!state.muted)
                begin
                    n.muted    = 1'b1;
                    n.square   = 1'b0;
                    n.beep_on  = 1'b0;
                    n.hold_sec = '0;
                    n.hold_sub = '0;
                end
                else if (ms_tick && !hold_sat)
                begin
                    if (n.hold_sub == HOLD_SUB_LAST)
                    begin
                        n.hold_sub = '0;
                        n.hold_sec = n.hold_sec + 1'b1;
                    end
                    else
                    begin
                        n.hold_sub = n.hold_sub + 1'b1;
                    end
                end

                // Countdown steps down by one toward the remaining seconds.
                if (n.hold_sec >= hold_seconds_ext)
                begin
                    target = '0;
                end
                else
                begin
                    target = HOLD_SECONDS_W'(hold_seconds_ext - n.hold_sec);
                end
                if (target < n.seconds_left)
                begin
                    n.seconds_left = n.seconds_left - 1'b1;
                end

                // Held longer than the configured seconds: dismiss.
                if ((n.hold_sec > hold_seconds_ext) ||
                    ((n.hold_sec == hold_seconds_ext) && (n.hold_sub != '0)))
                begin
                    n.active  = 1'b0;
                    n.muted   = 1'b0;
                    n.square  = 1'b0;
                    n.beep_on = 1'b0;
                    dis       = 1'b1;
                end
            end
            else
            begin
                // Released: unmute, reload the countdown, check the ring time.
                n.muted        = 1'b0;
                n.seconds_left = hold_seconds;
                if (n.ring_ms > max_ring_ms)
                begin
                    n.active  = 1'b0;
                    n.square  = 1'b0;
                    n.beep_on = 1'b0;
                    tmo       = 1'b1;
                end
            end

            // Tone tick toggles the square wave and, when due, the beep flag.
            if (n.active && !n.muted && tone_tick)
            begin
                if (n.beep_ms > beep_length_ms)
                begin
                    n.beep_on = ~n.beep_on;
                    n.beep_ms = '0;
                end
                n.square = ~n.square;
            end
        end
    end

    assign state_next = n;

    // Result word derived from the updated state.
    always_comb
    begin
        result.buzzer_level      = n.active && !n.muted && n.square && n.beep_on;
        result.led_level         = n.active && n.beep_on;
        result.ringing           = n.active;
        result.countdown_seconds = n.active ? n.seconds_left : '0;
        result.dismissed         = dis;
        result.timed_out         = tmo;
    end

endmodule

`default_nettype wire

/* src/long_press_alarm_dismiss.sv */
// Top level of the long-press alarm dismiss controller: handshakes,
// configuration registers, state and result registers. Uses lpad_pkg, lpad_step.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// item      in         item_valid/item_stall   start_alarm, button_held, ms_tick, tone_tick
// result    out        result_valid/result_stall  buzzer_level .. timed_out
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One tick word is taken per clock while item_stall is low; its result
// appears in the result register on the next cycle, set by one lpad_step pass.
// A new word is taken whenever the result register is empty or being taken.
// Reset loads the default register values and an idle, silent state.
// The configuration port is always ready.

module long_press_alarm_dismiss (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // Tick words.
    input  wire                                  item_valid,
    output logic                                 item_stall,
    input  wire                                  start_alarm,
    input  wire                                  button_held,
    input  wire                                  ms_tick,
    input  wire                                  tone_tick,
    // Result words.
    output logic                                 result_valid,
    input  wire                                  result_stall,
    output logic                                 buzzer_level,
    output logic                                 led_level,
    output logic                                 ringing,
    output logic [lpad_pkg::HOLD_SECONDS_W-1:0]  countdown_seconds,
    output logic                                 dismissed,
    output logic                                 timed_out,
    // Configuration writes.
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [lpad_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire [lpad_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import lpad_pkg::*;

    logic [HOLD_SECONDS_W-1:0] hold_seconds_reg;
    logic [RING_MS_W-1:0]      max_ring_ms_reg;
    logic [BEEP_MS_W-1:0]      beep_length_ms_reg;
    state_t                    state_reg;
    state_t                    state_next;
    result_t                   result_reg;
    result_t                   result_next;
    logic                      result_valid_reg;
    logic                      accept;

    // Flow control: the result register frees up when it is empty or taken.
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_seconds_reg   <= HOLD_SECONDS_RESET;
            max_ring_ms_reg    <= MAX_RING_MS_RESET;
            beep_length_ms_reg <= BEEP_LENGTH_MS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HOLD_SECONDS:   hold_seconds_reg   <= cfg_data[HOLD_SECONDS_W-1:0];
                REG_MAX_RING_MS:    max_ring_ms_reg    <= cfg_data[RING_MS_W-1:0];
                REG_BEEP_LENGTH_MS: beep_length_ms_reg <= cfg_data[BEEP_MS_W-1:0];
                default:            ;
            endcase
        end
    end

    // Per-word update logic.
    lpad_step u_step (
        .state          (state_reg),
        .start_alarm    (start_alarm),
        .button_held    (button_held),
        .ms_tick        (ms_tick),
        .tone_tick      (tone_tick),
        .hold_seconds   (hold_seconds_reg),
        .max_ring_ms    (max_ring_ms_reg),
        .beep_length_ms (beep_length_ms_reg),
        .state_next     (state_next),
        .result         (result_next)
    );

    // State register, advanced once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.active       <= 1'b0;
            state_reg.muted        <= 1'b0;
            state_reg.ring_ms      <= '0;
            state_reg.hold_sec     <= '0;
            state_reg.hold_sub     <= '0;
            state_reg.seconds_left <= HOLD_SECONDS_RESET;
            state_reg.beep_ms      <= '0;
            state_reg.beep_on      <= 1'b0;
            state_reg.square       <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid      = result_valid_reg;
    assign buzzer_level      = result_reg.buzzer_level;
    assign led_level         = result_reg.led_level;
    assign ringing           = result_reg.ringing;
    assign countdown_seconds = result_reg.countdown_seconds;
    assign dismissed         = result_reg.dismissed;
    assign timed_out         = result_reg.timed_out;

endmodule

`default_nettype wire
